// ===== rtl/segment_intersection_2d_macros.svh =====
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared property forms for the segment intersection checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_2D_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SEGI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SEGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/segi_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, word types and stage payloads shared by the intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

    // Coordinate width (two's complement, Q15.8)
    localparam int COORD_BITS = 24;
    // Tolerance register
    localparam int TOL_W = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(6);

    // Derived datapath widths
    localparam int DIFF_W  = COORD_BITS + 1;          // edge vectors
    localparam int PROD_W  = 2 * DIFF_W;              // one cross term
    localparam int CROSS_W = PROD_W + 1;              // cross product
    localparam int MAG_W   = CROSS_W - 1;             // cross magnitude
    localparam int RMAG_W  = COORD_BITS;              // |R| per axis
    localparam int Q_W     = COORD_BITS;              // quotient bits
    localparam int LO_W    = MAG_W / 2;               // low partial product
    localparam int HI_W    = MAG_W - LO_W;            // high partial product
    localparam int N_W     = RMAG_W + MAG_W;          // dividend |R|*|tn|
    localparam int CMP_W   = (MAG_W > TOL_W) ? MAG_W : TOL_W;

    // Input word: two segments
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } t_seg_in;

    // Output word: hit flag and intersection point
    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_seg_out;

    // Front end result: cross products and what the point needs
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a0x;
        logic signed [COORD_BITS-1:0] a0y;
        logic signed [DIFF_W-1:0]     rx;
        logic signed [DIFF_W-1:0]     ry;
        logic signed [CROSS_W-1:0]    den;
        logic signed [CROSS_W-1:0]    tn;
        logic signed [CROSS_W-1:0]    un;
    } t_front;

    // Divider payload: one restoring step per stage, both axes
    typedef struct packed {
        logic                         hit;
        logic                         neg_x;
        logic                         neg_y;
        logic signed [COORD_BITS-1:0] a0x;
        logic signed [COORD_BITS-1:0] a0y;
        logic [MAG_W-1:0]             d;
        logic [MAG_W-1:0]             rem_x;
        logic [Q_W-1:0]               low_x;
        logic [Q_W-1:0]               q_x;
        logic [MAG_W-1:0]             rem_y;
        logic [Q_W-1:0]               low_y;
        logic [Q_W-1:0]               q_y;
    } t_div;

endpackage

// ===== rtl/segi_front.sv =====
// ----------------------------------------------------------------------------
// Segment intersection front end
// Edge vectors, cross terms and the three cross products over three stages.
// ----------------------------------------------------------------------------
module segi_front import segi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_seg_in i_word,
    output logic    o_valid,
    output t_front  o_front
);

    // Stage 1 registers
    logic                         r_s1_v;
    logic signed [COORD_BITS-1:0] r_s1_a0x, r_s1_a0y;
    logic signed [DIFF_W-1:0]     r_rx, r_ry, r_sx, r_sy, r_dx, r_dy;
    logic signed [DIFF_W-1:0]     n_rx, n_ry, n_sx, n_sy, n_dx, n_dy;

    // Stage 2 registers
    logic                         r_s2_v;
    logic signed [COORD_BITS-1:0] r_s2_a0x, r_s2_a0y;
    logic signed [DIFF_W-1:0]     r_s2_rx, r_s2_ry;
    logic signed [PROD_W-1:0]     r_p_rs0, r_p_rs1, r_p_ds0, r_p_ds1, r_p_dr0, r_p_dr1;
    logic signed [PROD_W-1:0]     n_p_rs0, n_p_rs1, n_p_ds0, n_p_ds1, n_p_dr0, n_p_dr1;

    // Stage 3 registers
    logic   r_s3_v;
    t_front r_s3;
    t_front n_s3;

    // Form R = A1 - A0, S = B1 - B0, D = B0 - A0
    always_comb begin
        n_rx = DIFF_W'(i_word.a_end_x)   - DIFF_W'(i_word.a_start_x);
        n_ry = DIFF_W'(i_word.a_end_y)   - DIFF_W'(i_word.a_start_y);
        n_sx = DIFF_W'(i_word.b_end_x)   - DIFF_W'(i_word.b_start_x);
        n_sy = DIFF_W'(i_word.b_end_y)   - DIFF_W'(i_word.b_start_y);
        n_dx = DIFF_W'(i_word.b_start_x) - DIFF_W'(i_word.a_start_x);
        n_dy = DIFF_W'(i_word.b_start_y) - DIFF_W'(i_word.a_start_y);
    end

    // Six cross terms, one multiplier each
    always_comb begin
        n_p_rs0 = r_rx * r_sy;
        n_p_rs1 = r_ry * r_sx;
        n_p_ds0 = r_dx * r_sy;
        n_p_ds1 = r_dy * r_sx;
        n_p_dr0 = r_dx * r_ry;
        n_p_dr1 = r_dy * r_rx;
    end

    // Subtract the cross terms
    always_comb begin
        n_s3.a0x = r_s2_a0x;
        n_s3.a0y = r_s2_a0y;
        n_s3.rx  = r_s2_rx;
        n_s3.ry  = r_s2_ry;
        n_s3.den = CROSS_W'(r_p_rs0) - CROSS_W'(r_p_rs1);
        n_s3.tn  = CROSS_W'(r_p_ds0) - CROSS_W'(r_p_ds1);
        n_s3.un  = CROSS_W'(r_p_dr0) - CROSS_W'(r_p_dr1);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // Payload registers, advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a0x <= i_word.a_start_x;
            r_s1_a0y <= i_word.a_start_y;
            r_rx     <= n_rx;
            r_ry     <= n_ry;
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_s2_a0x <= r_s1_a0x;
            r_s2_a0y <= r_s1_a0y;
            r_s2_rx  <= r_rx;
            r_s2_ry  <= r_ry;
            r_p_rs0  <= n_p_rs0;
            r_p_rs1  <= n_p_rs1;
            r_p_ds0  <= n_p_ds0;
            r_p_ds1  <= n_p_ds1;
            r_p_dr0  <= n_p_dr0;
            r_p_dr1  <= n_p_dr1;
            r_s3     <= n_s3;
        end
    end

    assign o_valid = r_s3_v;
    assign o_front = r_s3;

endmodule

// ===== rtl/segi_scale.sv =====
// ----------------------------------------------------------------------------
// Segment intersection hit test and scaling
// Range checks, magnitudes, tolerance test and the |R|*|tn| dividend.
// ----------------------------------------------------------------------------
module segi_scale import segi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_front           i_front,
    input  logic [TOL_W-1:0] i_tol,
    output logic             o_valid,
    output t_div             o_div
);

    // Stage 4 registers
    logic                         r4_v;
    logic                         r4_unit, n4_unit;
    logic [MAG_W-1:0]             r4_dmag, r4_tmag, n4_dmag, n4_tmag;
    logic [RMAG_W-1:0]            r4_rxm, r4_rym, n4_rxm, n4_rym;
    logic                         r4_negx, r4_negy, n4_negx, n4_negy;
    logic signed [COORD_BITS-1:0] r4_a0x, r4_a0y;
    logic                         den_pos, t_in, u_in, den_neg, tn_neg, un_neg;

    // Stage 5 registers
    logic                         r5_v;
    logic                         r5_hit;
    logic [MAG_W-1:0]             r5_dmag;
    logic [RMAG_W+LO_W-1:0]       r5_plx, r5_ply;
    logic [RMAG_W+HI_W-1:0]       r5_phx, r5_phy;
    logic                         r5_negx, r5_negy;
    logic signed [COORD_BITS-1:0] r5_a0x, r5_a0y;
    logic                         n5_tol_ok;

    // Stage 6 register
    logic             r6_v;
    t_div             r6;
    t_div             n6;
    logic [N_W-1:0]   n6_nx, n6_ny;

    // Check t and u in [0,1] by sign and magnitude; take magnitudes
    always_comb begin
        den_neg = i_front.den[CROSS_W-1];
        tn_neg  = i_front.tn[CROSS_W-1];
        un_neg  = i_front.un[CROSS_W-1];
        den_pos = !den_neg && (i_front.den != '0);
        if (den_pos) begin
            t_in = !tn_neg && (i_front.tn <= i_front.den);
            u_in = !un_neg && (i_front.un <= i_front.den);
        end else begin
            t_in = (tn_neg || i_front.tn == '0) && (i_front.tn >= i_front.den);
            u_in = (un_neg || i_front.un == '0) && (i_front.un >= i_front.den);
        end
        n4_unit = t_in && u_in;
        n4_dmag = den_neg ? MAG_W'(-i_front.den) : MAG_W'(i_front.den);
        n4_tmag = tn_neg ? MAG_W'(-i_front.tn) : MAG_W'(i_front.tn);
        n4_rxm  = i_front.rx[DIFF_W-1] ? RMAG_W'(-i_front.rx) : RMAG_W'(i_front.rx);
        n4_rym  = i_front.ry[DIFF_W-1] ? RMAG_W'(-i_front.ry) : RMAG_W'(i_front.ry);
        n4_negx = i_front.rx[DIFF_W-1] ^ tn_neg ^ den_neg;
        n4_negy = i_front.ry[DIFF_W-1] ^ tn_neg ^ den_neg;
    end

    // Reject nearly parallel pairs
    assign n5_tol_ok = CMP_W'(r4_dmag) > CMP_W'(i_tol);

    // Join the partial products into the dividend, load the divider
    always_comb begin
        n6_nx = (N_W'(r5_phx) << LO_W) + N_W'(r5_plx);
        n6_ny = (N_W'(r5_phy) << LO_W) + N_W'(r5_ply);
        n6.hit   = r5_hit;
        n6.neg_x = r5_negx;
        n6.neg_y = r5_negy;
        n6.a0x   = r5_a0x;
        n6.a0y   = r5_a0y;
        n6.d     = r5_dmag;
        n6.rem_x = n6_nx[N_W-1:Q_W];
        n6.low_x = n6_nx[Q_W-1:0];
        n6.q_x   = '0;
        n6.rem_y = n6_ny[N_W-1:Q_W];
        n6.low_y = n6_ny[Q_W-1:0];
        n6.q_y   = '0;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= i_valid;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // Payload registers; partial products split |tn| in two halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_unit <= n4_unit;
            r4_dmag <= n4_dmag;
            r4_tmag <= n4_tmag;
            r4_rxm  <= n4_rxm;
            r4_rym  <= n4_rym;
            r4_negx <= n4_negx;
            r4_negy <= n4_negy;
            r4_a0x  <= i_front.a0x;
            r4_a0y  <= i_front.a0y;
            r5_hit  <= r4_unit && n5_tol_ok;
            r5_dmag <= r4_dmag;
            r5_plx  <= r4_rxm * r4_tmag[LO_W-1:0];
            r5_phx  <= r4_rxm * r4_tmag[MAG_W-1:LO_W];
            r5_ply  <= r4_rym * r4_tmag[LO_W-1:0];
            r5_phy  <= r4_rym * r4_tmag[MAG_W-1:LO_W];
            r5_negx <= r4_negx;
            r5_negy <= r4_negy;
            r5_a0x  <= r4_a0x;
            r5_a0y  <= r4_a0y;
            r6      <= n6;
        end
    end

    assign o_valid = r6_v;
    assign o_div   = r6;

endmodule

// ===== rtl/segi_div_stage.sv =====
// ----------------------------------------------------------------------------
// Segment intersection divider stage
// One restoring division step per axis: one quotient bit per stage.
// ----------------------------------------------------------------------------
module segi_div_stage import segi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_div o_div
);

    logic             r_v;
    t_div             r_div;
    t_div             n_div;
    logic [MAG_W:0]   trial_x, trial_y;
    logic             ge_x, ge_y;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial_x = {i_div.rem_x, i_div.low_x[Q_W-1]};
        trial_y = {i_div.rem_y, i_div.low_y[Q_W-1]};
        ge_x    = trial_x >= {1'b0, i_div.d};
        ge_y    = trial_y >= {1'b0, i_div.d};
        n_div       = i_div;
        n_div.rem_x = ge_x ? MAG_W'(trial_x - {1'b0, i_div.d}) : MAG_W'(trial_x);
        n_div.rem_y = ge_y ? MAG_W'(trial_y - {1'b0, i_div.d}) : MAG_W'(trial_y);
        n_div.low_x = i_div.low_x << 1;
        n_div.low_y = i_div.low_y << 1;
        n_div.q_x   = {i_div.q_x[Q_W-2:0], ge_x};
        n_div.q_y   = {i_div.q_y[Q_W-2:0], ge_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_v;
    assign o_div   = r_div;

endmodule

// ===== rtl/segi_outbuf.sv =====
// ----------------------------------------------------------------------------
// Segment intersection output buffer
// Applies the quotient sign, zeroes misses, and holds two result words.
// ----------------------------------------------------------------------------
module segi_outbuf import segi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_div     i_div,
    input  logic     i_out_stall,
    output logic     o_out_valid,
    output t_seg_out o_out_word,
    output logic     o_adv
);

    logic                  r_out_v, n_out_v;
    logic                  r_skid_v, n_skid_v;
    t_seg_out              r_out, r_skid;
    t_seg_out              n_word;
    logic [COORD_BITS-1:0] off_x, off_y;
    logic                  take, load_out_in, load_out_skid, load_skid;

    // Point = A0 + signed quotient; zero on a miss
    always_comb begin
        off_x = i_div.neg_x ? (COORD_BITS'(0) - i_div.q_x) : i_div.q_x;
        off_y = i_div.neg_y ? (COORD_BITS'(0) - i_div.q_y) : i_div.q_y;
        n_word.hit     = i_div.hit;
        n_word.cross_x = i_div.hit ? (i_div.a0x + off_x) : '0;
        n_word.cross_y = i_div.hit ? (i_div.a0y + off_y) : '0;
    end

    // Route the incoming word to the output or the skid register
    always_comb begin
        take          = r_out_v && !i_out_stall;
        load_out_in   = !r_skid_v && i_valid && (!r_out_v || take);
        load_skid     = !r_skid_v && i_valid && r_out_v && !take;
        load_out_skid = r_skid_v && take;
        n_out_v       = r_out_v;
        n_skid_v      = r_skid_v;
        if (load_out_in || load_out_skid) begin
            n_out_v = 1'b1;
        end else if (take) begin
            n_out_v = 1'b0;
        end
        if (load_skid) begin
            n_skid_v = 1'b1;
        end else if (load_out_skid) begin
            n_skid_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_in) begin
            r_out <= n_word;
        end else if (load_out_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= n_word;
        end
    end

    // Hold the pipeline only while the skid register is occupied
    assign o_adv       = !r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/segment_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// Segment intersection 2D, top level
// Tests two fixed-point segments for intersection and returns the crossing.
//
//   channel  direction  handshake                     payload
//   in       input      i_in_valid / o_in_stall       i_in_word  (t_seg_in)
//   out      output     o_out_valid / i_out_stall     o_out_word (t_seg_out)
//   cfg      input      i_cfg_valid / o_cfg_ready     i_cfg_data (tolerance)
//
// One word enters per cycle while o_in_stall is low; each word gives one result
// word after three front stages (differences, multipliers, cross products),
// three scaling stages, one restoring divider stage per quotient bit (24), and
// the output register. Reset clears all valid bits and sets the tolerance to 6.
// A stalled output fills a skid register; o_in_stall is that register's
// occupancy and freezes the whole pipeline until the output word is taken.
// ----------------------------------------------------------------------------
module segment_intersection_2d import segi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_seg_in          i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_seg_out         o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TOL_W-1:0] i_cfg_data
);

    logic [TOL_W-1:0] r_tol;
    logic             adv;
    logic             front_v;
    t_front           front;
    t_div             w_div   [0:Q_W];
    logic             w_div_v [0:Q_W];

    // Tolerance register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    assign o_in_stall = !adv;

    segi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_valid (front_v),
        .o_front (front)
    );

    segi_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (front_v),
        .i_front (front),
        .i_tol   (r_tol),
        .o_valid (w_div_v[0]),
        .o_div   (w_div[0])
    );

    // Divider chain, one quotient bit per stage
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        segi_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (w_div_v[k]),
            .i_div   (w_div[k]),
            .o_valid (w_div_v[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    segi_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_div_v[Q_W]),
        .i_div       (w_div[Q_W]),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_adv       (adv)
    );

endmodule

// ===== rtl/segi_checker.sv =====
// ----------------------------------------------------------------------------
// Segment intersection port checker
// Port-level properties of the intersection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_intersection_2d_macros.svh"

module segi_checker import segi_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_seg_out         o_out_word
);

    // A stalled result word stays put
    `SEGI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "output word changed while stalled")

    // A miss carries a zero point
    `SEGI_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.hit, o_out_word.cross_x == '0 && o_out_word.cross_y == '0, "miss with nonzero point")

    // Input back-pressure only follows a stalled output word
    `SEGI_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall), $past(o_out_valid && i_out_stall), "input stall without output stall")

    // While the input is held, a result word is waiting
    `SEGI_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid, "input stalled with empty output")

endmodule

bind segment_intersection_2d segi_checker u_segi_checker (.*);
